@@ sv/mass_spring_cloth_step_top_assert.svh @@
// Assertion macros shared by the cloth step RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef MASS_SPRING_CLOTH_STEP_TOP_ASSERT_SVH
`define MASS_SPRING_CLOTH_STEP_TOP_ASSERT_SVH
// Same-cycle implication, idle during reset.
`define MSC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, idle during reset.
`define MSC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ sv/msc_pkg.sv @@
// Shared grid constants, command/status structs and fixed-point helpers
// for the cloth step block. No dependencies.
`default_nettype none
package msc_pkg;

  localparam int COLS      = 11;
  localparam int ROWS      = 10;
  localparam int NPTS      = ROWS * COLS;
  localparam int PT_W      = $clog2(NPTS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int COL_W     = $clog2(COLS);
  localparam int X_SPACING = 78643;

  localparam logic [63:0] D2_ONE = 64'h0000_0001_0000_0000;

  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef logic signed [31:0] word_t;
  typedef word_t [2:0]        vec3_t;
  typedef logic signed [69:0] prod_t;

  typedef enum logic [2:0] {
    REG_GRAVITY     = 3'd0,
    REG_WIND_X      = 3'd1,
    REG_WIND_Y      = 3'd2,
    REG_WIND_Z      = 3'd3,
    REG_WIND_FACTOR = 3'd4,
    REG_SPRING_GAIN = 3'd5,
    REG_DAMPING     = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    M_NONE, M_GRAV_DT, M_DAMP_DT, M_WIND_DT, M_WTMP_WF, M_DIFF_SQ,
    M_D_DT, M_K0_GAIN, M_DIFF_K, M_V_M, M_V_DT
  } mul_op_t;

  typedef struct packed {
    mul_op_t         mul;
    logic [1:0]      comp;
    logic            rd_pos;
    logic            rd_vel;
    logic [PT_W-1:0] addr_a;
    logic [PT_W-1:0] addr_b;
    logic            ld_dt;
    logic            diff;
    logic            sqrt_go;
    logic            v_load;
    logic            v_grav;
    logic            v_wind;
    logic            v_store;
    logic            p_store;
    logic            out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic spring_on;
    logic sqrt_busy;
    logic out_busy;
  } dp_sts_t;

  // arithmetic shift that truncates toward zero
  function automatic prod_t shr_tz(input prod_t p, input int unsigned s);
    prod_t mag;
    mag = p[69] ? -p : p;
    mag = mag >> s;
    return p[69] ? -mag : mag;
  endfunction

  function automatic word_t sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -72'sd2147483648) return 32'sh80000000;
    return $signed(v[31:0]);
  endfunction

  function automatic logic is_anchor(input logic [PT_W-1:0] idx);
    return (idx == PT_W'(0)) || (idx == PT_W'(COLS / 2)) || (idx == PT_W'(COLS - 1));
  endfunction

  // rest grid position of a point
  function automatic vec3_t pos_init(input logic [PT_W-1:0] idx);
    int    row;
    int    col;
    vec3_t p;
    row = 0;
    for (int r = 1; r < ROWS; r++) begin
      if (int'(idx) >= r * COLS) row = r;
    end
    col  = int'(idx) - row * COLS;
    p[0] = 32'(col * X_SPACING);
    p[1] = 32'(row * 65536);
    p[2] = '0;
    return p;
  endfunction

endpackage
`default_nettype wire

@@ sv/msc_sqrt.sv @@
// Iterative 64-bit integer square root, one result bit per cycle.
// Standalone; used by the cloth datapath.
`default_nettype none
module msc_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [63:0] rad,
  output logic             busy,
  output logic [31:0]      root
);

  logic [63:0] num_r, num_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] one_r, one_nxt;
  logic        busy_r, busy_nxt;
  logic [63:0] trial;

  assign trial = res_r + one_r;

  always_comb begin
    num_nxt  = num_r;
    res_nxt  = res_r;
    one_nxt  = one_r;
    busy_nxt = busy_r;
    if (go) begin
      num_nxt  = rad;
      res_nxt  = '0;
      one_nxt  = 64'h4000_0000_0000_0000;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (num_r >= trial) begin
        num_nxt = num_r - trial;
        res_nxt = (res_r >> 1) + one_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      one_nxt  = one_r >> 2;
      busy_nxt = (one_r != 64'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    num_r <= num_nxt;
    res_r <= res_nxt;
    one_r <= one_nxt;
  end

  assign busy = busy_r;
  assign root = res_r[31:0];

endmodule
`default_nettype wire

@@ sv/msc_dp.sv @@
// Cloth datapath: state memories, config registers, shared multiplier,
// square root unit and result register. Uses msc_pkg and msc_sqrt.
`default_nettype none
module msc_dp
  import msc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  output dp_sts_t          sts,
  input  wire logic [15:0] in_dt,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_point_number,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic             out_is_anchor
);

  // configuration
  logic signed [31:0] grav_r;
  logic signed [19:0] wind_r [3];
  logic [16:0]        wf_r;
  logic [22:0]        gain_r;
  logic [16:0]        damp_r;

  // per-step constants
  logic [15:0]        dt_r;
  logic signed [32:0] grav_inc_r;
  word_t              wind_inc_r [3];
  logic [16:0]        m_r;
  logic signed [35:0] wtmp_r;

  // per-point work registers
  word_t       v_r [3];
  word_t       diff_r [3];
  word_t       pnew_r [3];
  logic [63:0] d2_r;
  logic [31:0] k0_r;
  logic [30:0] k_r;

  // memories and read registers
  vec3_t           pos_mem [NPTS];
  vec3_t           vel_mem [NPTS];
  logic [NPTS-1:0] pos_vld_r;
  logic [NPTS-1:0] vel_vld_r;
  vec3_t           pos_a_q, pos_b_q, vel_q;
  logic            pos_va_q, pos_vb_q, vel_v_q;
  logic [PT_W-1:0] addr_a_q, addr_b_q;
  vec3_t           pa, pb, vel_rd;

  // multiplier
  logic signed [36:0] mul_a;
  logic signed [32:0] mul_b;
  prod_t              prod_r;
  mul_op_t            pend_op_r;
  logic [1:0]         pend_comp_r;
  prod_t              prod_s16;
  prod_t              prod_s32;
  logic [17:0]        damp_q;
  logic [16:0]        m_nxt;

  // sqrt
  logic        sq_busy;
  logic [31:0] sq_root;

  // result register
  logic              out_valid_r;
  logic [7:0]        out_num_r;
  vec3_t             out_pos_r;
  logic              out_anc_r;

  msc_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.sqrt_go),
    .rad  (d2_r),
    .busy (sq_busy),
    .root (sq_root)
  );

  assign pa     = pos_va_q ? pos_a_q : pos_init(addr_a_q);
  assign pb     = pos_vb_q ? pos_b_q : pos_init(addr_b_q);
  assign vel_rd = vel_v_q ? vel_q : '0;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul)
      M_GRAV_DT: begin
        mul_a = 37'(grav_r);
        mul_b = $signed({17'd0, dt_r});
      end
      M_DAMP_DT: begin
        mul_a = $signed({20'd0, damp_r});
        mul_b = $signed({17'd0, dt_r});
      end
      M_WIND_DT: begin
        mul_a = 37'(wind_r[cmd.comp]);
        mul_b = $signed({17'd0, dt_r});
      end
      M_WTMP_WF: begin
        mul_a = 37'(wtmp_r);
        mul_b = $signed({16'd0, wf_r});
      end
      M_DIFF_SQ: begin
        mul_a = 37'(diff_r[cmd.comp]);
        mul_b = 33'(diff_r[cmd.comp]);
      end
      M_D_DT: begin
        mul_a = $signed({5'd0, sq_root});
        mul_b = $signed({17'd0, dt_r});
      end
      M_K0_GAIN: begin
        mul_a = $signed({5'd0, k0_r});
        mul_b = $signed({10'd0, gain_r});
      end
      M_DIFF_K: begin
        mul_a = 37'(diff_r[cmd.comp]);
        mul_b = $signed({2'd0, k_r});
      end
      M_V_M: begin
        mul_a = 37'(v_r[cmd.comp]);
        mul_b = $signed({16'd0, m_r});
      end
      M_V_DT: begin
        mul_a = 37'($signed(vel_rd[cmd.comp]));
        mul_b = $signed({17'd0, dt_r});
      end
      default: ;
    endcase
  end

  assign prod_s16 = shr_tz(prod_r, 16);
  assign prod_s32 = shr_tz(prod_r, 32);
  assign damp_q   = prod_r[33:16];
  assign m_nxt    = (damp_q > 18'd65536) ? 17'd0 : 17'(18'd65536 - damp_q);

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r      <= 32'sd131072;
      wind_r[0]   <= '0;
      wind_r[1]   <= '0;
      wind_r[2]   <= '0;
      wf_r        <= 17'd45875;
      gain_r      <= 23'd1310720;
      damp_r      <= 17'd19661;
      pend_op_r   <= M_NONE;
      pos_vld_r   <= '0;
      vel_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_GRAVITY:     grav_r    <= $signed(cfg_data);
          REG_WIND_X:      wind_r[0] <= $signed(cfg_data[19:0]);
          REG_WIND_Y:      wind_r[1] <= $signed(cfg_data[19:0]);
          REG_WIND_Z:      wind_r[2] <= $signed(cfg_data[19:0]);
          REG_WIND_FACTOR: wf_r      <= cfg_data[16:0];
          REG_SPRING_GAIN: gain_r    <= cfg_data[22:0];
          REG_DAMPING:     damp_r    <= cfg_data[16:0];
          default: ;
        endcase
      end
      pend_op_r <= cmd.mul;
      if (cmd.p_store) pos_vld_r[cmd.addr_a] <= 1'b1;
      if (cmd.v_store) vel_vld_r[cmd.addr_a] <= 1'b1;
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.rd_pos) begin
      pos_a_q  <= pos_mem[cmd.addr_a];
      pos_b_q  <= pos_mem[cmd.addr_b];
      pos_va_q <= pos_vld_r[cmd.addr_a];
      pos_vb_q <= pos_vld_r[cmd.addr_b];
      addr_a_q <= cmd.addr_a;
      addr_b_q <= cmd.addr_b;
    end
    if (cmd.rd_vel) begin
      vel_q   <= vel_mem[cmd.addr_a];
      vel_v_q <= vel_vld_r[cmd.addr_a];
    end
    if (cmd.p_store) pos_mem[cmd.addr_a] <= {pnew_r[2], pnew_r[1], pnew_r[0]};
    if (cmd.v_store) vel_mem[cmd.addr_a] <= {v_r[2], v_r[1], v_r[0]};
  end

  // arithmetic
  always_ff @(posedge clk) begin
    prod_r      <= mul_a * mul_b;
    pend_comp_r <= cmd.comp;
    if (cmd.ld_dt) dt_r <= in_dt;
    if (cmd.diff) begin
      for (int c = 0; c < 3; c++) begin
        diff_r[c] <= sat32(72'($signed(pa[c])) - 72'($signed(pb[c])));
      end
      d2_r <= '0;
    end
    if (cmd.v_load) begin
      for (int c = 0; c < 3; c++) v_r[c] <= $signed(vel_rd[c]);
    end
    if (cmd.v_grav) v_r[1] <= sat32(72'(v_r[1]) + 72'(grav_inc_r));
    if (cmd.v_wind) begin
      for (int c = 0; c < 3; c++) v_r[c] <= sat32(72'(v_r[c]) + 72'(wind_inc_r[c]));
    end
    case (pend_op_r)
      M_GRAV_DT: grav_inc_r <= $signed(prod_s16[32:0]);
      M_DAMP_DT: m_r        <= m_nxt;
      M_WIND_DT: wtmp_r     <= $signed(prod_r[35:0]);
      M_WTMP_WF: begin
        wind_inc_r[pend_comp_r] <= prod_s32[31:0];
      end
      M_DIFF_SQ: d2_r <= d2_r + prod_r[63:0];
      M_D_DT:    k0_r <= prod_r[47:16];
      M_K0_GAIN: k_r  <= (|prod_r[69:47]) ? 31'h7FFF_FFFF : prod_r[46:16];
      M_DIFF_K: begin
        v_r[pend_comp_r] <= sat32(72'(v_r[pend_comp_r]) - 72'(prod_s16));
      end
      M_V_M:     v_r[pend_comp_r] <= sat32(72'(prod_s16));
      M_V_DT: begin
        pnew_r[pend_comp_r] <= sat32(72'($signed(pa[pend_comp_r])) + 72'(prod_s16));
      end
      default: ;
    endcase
    if (cmd.out_ld) begin
      out_num_r <= 8'(addr_a_q);
      out_pos_r <= pa;
      out_anc_r <= is_anchor(addr_a_q);
    end
  end

  assign sts.spring_on = (d2_r > D2_ONE);
  assign sts.sqrt_busy = sq_busy;
  assign sts.out_busy  = out_valid_r && !out_ready;

  assign out_valid        = out_valid_r;
  assign out_point_number = out_num_r;
  assign out_pos_x        = out_pos_r[0];
  assign out_pos_y        = out_pos_r[1];
  assign out_pos_z        = out_pos_r[2];
  assign out_is_anchor    = out_anc_r;

endmodule
`default_nettype wire

@@ sv/msc_ctrl.sv @@
// Cloth step sequencer: walks the grid, schedules the shared multiplier
// and square root, and handles read commands. Uses msc_pkg.
`default_nettype none
`include "mass_spring_cloth_step_top_assert.svh"
module msc_ctrl
  import msc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_cmd,
  input  wire logic [7:0] in_point_index,
  output dp_cmd_t         cmd,
  input  wire dp_sts_t    sts
);

  typedef enum logic [4:0] {
    S_IDLE, S_PRE, S_VRD, S_VGET, S_NB, S_DIFF, S_SQ, S_SQW, S_CHK, S_SQRT,
    S_KDT, S_KW1, S_KGN, S_KW2, S_DK, S_NXT, S_GRAV, S_WIND, S_DAMP, S_DW,
    S_VST, S_PRD, S_PMUL, S_PW, S_PST, S_RRD, S_ROUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [PT_W-1:0]  pt_r, pt_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [1:0]       nbr_r, nbr_nxt;
  logic [3:0]       sub_r, sub_nxt;
  logic             has_nb;
  logic [PT_W-1:0]  nb_addr;
  logic             last_pt;

  always_comb begin
    case (nbr_r)
      2'd0: begin
        has_nb  = (row_r != '0);
        nb_addr = pt_r - PT_W'(COLS);
      end
      2'd1: begin
        has_nb  = (row_r != ROW_W'(ROWS - 1));
        nb_addr = pt_r + PT_W'(COLS);
      end
      2'd2: begin
        has_nb  = (col_r != '0);
        nb_addr = pt_r - PT_W'(1);
      end
      default: begin
        has_nb  = (col_r != COL_W'(COLS - 1));
        nb_addr = pt_r + PT_W'(1);
      end
    endcase
  end

  assign last_pt  = (pt_r == PT_W'(NPTS - 1));
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    pt_nxt      = pt_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    nbr_nxt     = nbr_r;
    sub_nxt     = sub_r;
    cmd         = '0;
    cmd.mul     = M_NONE;
    cmd.addr_a  = pt_r;
    cmd.addr_b  = nb_addr;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_STEP) begin
            cmd.ld_dt = 1'b1;
            pt_nxt    = '0;
            row_nxt   = '0;
            col_nxt   = '0;
            sub_nxt   = '0;
            state_nxt = S_PRE;
          end else if ({1'b0, in_point_index} < 9'(NPTS)) begin
            pt_nxt    = in_point_index[PT_W-1:0];
            state_nxt = S_RRD;
          end
        end
      end
      S_PRE: begin
        sub_nxt = sub_r + 4'd1;
        case (sub_r)
          4'd0:  cmd.mul = M_GRAV_DT;
          4'd1:  cmd.mul = M_DAMP_DT;
          4'd2:  begin cmd.mul = M_WIND_DT; cmd.comp = 2'd0; end
          4'd4:  begin cmd.mul = M_WTMP_WF; cmd.comp = 2'd0; end
          4'd5:  begin cmd.mul = M_WIND_DT; cmd.comp = 2'd1; end
          4'd7:  begin cmd.mul = M_WTMP_WF; cmd.comp = 2'd1; end
          4'd8:  begin cmd.mul = M_WIND_DT; cmd.comp = 2'd2; end
          4'd10: begin cmd.mul = M_WTMP_WF; cmd.comp = 2'd2; end
          4'd11: state_nxt = S_VRD;
          default: ;
        endcase
      end
      S_VRD: begin
        cmd.rd_vel = 1'b1;
        state_nxt  = S_VGET;
      end
      S_VGET: begin
        cmd.v_load = 1'b1;
        nbr_nxt    = '0;
        sub_nxt    = '0;
        state_nxt  = is_anchor(pt_r) ? S_DAMP : S_NB;
      end
      S_NB: begin
        if (has_nb) begin
          cmd.rd_pos = 1'b1;
          state_nxt  = S_DIFF;
        end else begin
          state_nxt  = S_NXT;
        end
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        sub_nxt   = '0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.mul  = M_DIFF_SQ;
        cmd.comp = sub_r[1:0];
        sub_nxt  = sub_r + 4'd1;
        if (sub_r == 4'd2) state_nxt = S_SQW;
      end
      S_SQW: state_nxt = S_CHK;
      S_CHK: begin
        if (sts.spring_on) begin
          cmd.sqrt_go = 1'b1;
          state_nxt   = S_SQRT;
        end else begin
          state_nxt   = S_NXT;
        end
      end
      S_SQRT: if (!sts.sqrt_busy) state_nxt = S_KDT;
      S_KDT: begin
        cmd.mul   = M_D_DT;
        state_nxt = S_KW1;
      end
      S_KW1: state_nxt = S_KGN;
      S_KGN: begin
        cmd.mul   = M_K0_GAIN;
        state_nxt = S_KW2;
      end
      S_KW2: begin
        sub_nxt   = '0;
        state_nxt = S_DK;
      end
      S_DK: begin
        cmd.mul  = M_DIFF_K;
        cmd.comp = sub_r[1:0];
        sub_nxt  = sub_r + 4'd1;
        if (sub_r == 4'd2) state_nxt = S_NXT;
      end
      S_NXT: begin
        if (nbr_r == 2'd3) begin
          state_nxt = S_GRAV;
        end else begin
          nbr_nxt   = nbr_r + 2'd1;
          state_nxt = S_NB;
        end
      end
      S_GRAV: begin
        cmd.v_grav = 1'b1;
        state_nxt  = S_WIND;
      end
      S_WIND: begin
        cmd.v_wind = 1'b1;
        sub_nxt    = '0;
        state_nxt  = S_DAMP;
      end
      S_DAMP: begin
        cmd.mul  = M_V_M;
        cmd.comp = sub_r[1:0];
        sub_nxt  = sub_r + 4'd1;
        if (sub_r == 4'd2) state_nxt = S_DW;
      end
      S_DW: state_nxt = S_VST;
      S_VST: begin
        cmd.v_store = 1'b1;
        if (last_pt) begin
          pt_nxt    = '0;
          state_nxt = S_PRD;
        end else begin
          pt_nxt = pt_r + PT_W'(1);
          if (col_r == COL_W'(COLS - 1)) begin
            col_nxt = '0;
            row_nxt = row_r + ROW_W'(1);
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
          state_nxt = S_VRD;
        end
      end
      S_PRD: begin
        cmd.rd_pos = 1'b1;
        cmd.rd_vel = 1'b1;
        sub_nxt    = '0;
        state_nxt  = S_PMUL;
      end
      S_PMUL: begin
        cmd.mul  = M_V_DT;
        cmd.comp = sub_r[1:0];
        sub_nxt  = sub_r + 4'd1;
        if (sub_r == 4'd2) state_nxt = S_PW;
      end
      S_PW: state_nxt = S_PST;
      S_PST: begin
        cmd.p_store = 1'b1;
        if (last_pt) begin
          state_nxt = S_IDLE;
        end else begin
          pt_nxt    = pt_r + PT_W'(1);
          state_nxt = S_PRD;
        end
      end
      S_RRD: begin
        cmd.rd_pos = 1'b1;
        state_nxt  = S_ROUT;
      end
      S_ROUT: begin
        if (!sts.out_busy) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pt_r    <= '0;
      row_r   <= '0;
      col_r   <= '0;
      nbr_r   <= '0;
      sub_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pt_r    <= pt_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      nbr_r   <= nbr_nxt;
      sub_r   <= sub_nxt;
    end
  end

  `MSC_ASSERT_IMPL(a_sqrt_free, cmd.sqrt_go, !sts.sqrt_busy, "sqrt restarted while busy")
  `MSC_ASSERT_IMPL(a_out_free, cmd.out_ld, !sts.out_busy, "pending result overwritten")
  `MSC_ASSERT_NEXT(a_step_pre, in_valid && in_ready && in_cmd == CMD_STEP, state_r == S_PRE, "step did not start")
  `MSC_ASSERT_NEXT(a_sqrt_done, state_r == S_SQRT && !sts.sqrt_busy, state_r == S_KDT, "sqrt result dropped")

endmodule
`default_nettype wire

@@ sv/mass_spring_cloth_step_top.sv @@
// Mass-spring cloth step block, top level: sequencer plus datapath.
// Depends on msc_pkg, msc_ctrl, msc_dp (and msc_sqrt below it).
//
// Usage:
//  - in_* channel (valid/ready): in_cmd step advances the cloth by in_dt
//    (unsigned Q0.16); in_cmd read reports point in_point_index.
//  - out_* channel (valid/ready): one transfer per in-range read, carrying
//    the point index, its Q16.16 position and its anchor flag. Steps and
//    out-of-range reads give no transfer.
//  - cfg_* port: write cfg_data to register cfg_index when cfg_we is high;
//    write only while the block is idle.
//  - A read passes through S_RRD (position read) and S_ROUT (result
//    load), and waits in S_ROUT while an earlier result is pending.
//  - A step runs a preparation pass, a velocity pass (anchored points skip
//    the springs; free points visit each present neighbor, and one
//    stretched past rest length runs the square root loop, which dominates
//    its cost) and a position pass over the default 11x10 grid.
//  - One item is worked on at a time; in_ready is high only when idle.
//  - When the receiver stalls, the result is held in the output register;
//    the block still takes the next item, and a later read waits for it.
//  - Reset (rst_n low, synchronous) restores the rest grid, zero velocity
//    and default registers at once through per-entry valid bits.
`default_nettype none
module mass_spring_cloth_step_top
  import msc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_cmd,
  input  wire logic [15:0]        in_dt,
  input  wire logic [7:0]         in_point_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_point_number,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z,
  output logic                    out_is_anchor,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  // commands flow down, status flows back up
  dp_cmd_t cmd;
  dp_sts_t sts;

  msc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_point_index(in_point_index),
    .cmd           (cmd),
    .sts           (sts)
  );

  msc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_dt           (in_dt),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_point_number(out_point_number),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_pos_z       (out_pos_z),
    .out_is_anchor   (out_is_anchor)
  );

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the mass-spring cloth step block: random and directed
// step/read traffic with a bit-exact cloth predictor. Depends on msc_pkg and the RTL.
`default_nettype none

typedef longint unsigned u64_t;

typedef struct {
  logic [7:0]         point_number;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic               is_anchor;
} point_report_t;

class cloth_scoreboard;
  localparam int NP = msc_pkg::NPTS;
  localparam int NC = msc_pkg::COLS;
  localparam int NR = msc_pkg::ROWS;

  int            pos [NP][3];
  int            vel [NP][3];
  bit            pinned [NP];
  logic [31:0]   gravity;
  logic [19:0]   wind [3];
  logic [16:0]   wind_factor;
  logic [22:0]   gain;
  logic [16:0]   damping;
  point_report_t reports_due [$];
  int            errors;

  function new();
    errors = 0;
    gravity = 32'd131072;
    foreach (wind[k]) wind[k] = '0;
    wind_factor = 17'd45875;
    gain = 23'd1310720;
    damping = 17'd19661;
    for (int r = 0; r < NR; r++) begin
      for (int c = 0; c < NC; c++) begin
        pos[r*NC+c][0] = c * msc_pkg::X_SPACING;
        pos[r*NC+c][1] = r * 65536;
        pos[r*NC+c][2] = 0;
        for (int k = 0; k < 3; k++) vel[r*NC+c][k] = 0;
        pinned[r*NC+c] = 0;
      end
    end
    pinned[0] = 1;
    pinned[NC/2] = 1;
    pinned[NC-1] = 1;
  endfunction

  function int clamp_word(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // shift right, rounding toward zero
  function longint shift_tz(longint v, int s);
    u64_t mag;
    if (v < 0) begin
      mag = u64_t'(-v) >> s;
      return -longint'(mag);
    end
    return longint'(u64_t'(v) >> s);
  endfunction

  function u64_t root_floor(u64_t n);
    u64_t r;
    u64_t b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      msc_pkg::REG_GRAVITY:     gravity = data;
      msc_pkg::REG_WIND_X:      wind[0] = data[19:0];
      msc_pkg::REG_WIND_Y:      wind[1] = data[19:0];
      msc_pkg::REG_WIND_Z:      wind[2] = data[19:0];
      msc_pkg::REG_WIND_FACTOR: wind_factor = data[16:0];
      msc_pkg::REG_SPRING_GAIN: gain = data[22:0];
      msc_pkg::REG_DAMPING:     damping = data[16:0];
      default: ;
    endcase
  endfunction

  // pull point i toward neighbor j when stretched past rest length
  function void pull(int i, int j, u64_t dt);
    longint diff [3];
    u64_t   d2;
    u64_t   d;
    longint k;
    d2 = 0;
    for (int c = 0; c < 3; c++) begin
      diff[c] = clamp_word(longint'(pos[i][c]) - longint'(pos[j][c]));
      d2 += u64_t'(diff[c] * diff[c]);
    end
    if (d2 <= 64'h1_0000_0000) return;
    d = root_floor(d2);
    k = longint'((d * dt) >> 16);
    k = longint'((u64_t'(k) * u64_t'(gain)) >> 16);
    if (k > 64'sd2147483647) k = 64'sd2147483647;
    for (int c = 0; c < 3; c++)
      vel[i][c] = clamp_word(longint'(vel[i][c]) - shift_tz(diff[c] * k, 16));
  endfunction

  function void advance(u64_t dt);
    longint grav;
    longint wv [3];
    longint wf;
    longint m;
    int     rr;
    int     cc;
    int     i;
    grav = longint'($signed(gravity));
    for (int k = 0; k < 3; k++) wv[k] = longint'($signed(wind[k]));
    wf = longint'(wind_factor);
    m = 65536 - longint'((u64_t'(damping) * dt) >> 16);
    if (m < 0) m = 0;
    for (int r = 0; r < NR; r++) begin
      for (int c = 0; c < NC; c++) begin
        i = r * NC + c;
        if (!pinned[i]) begin
          for (int n = 0; n < 4; n++) begin
            rr = r + (n == 0 ? -1 : n == 1 ? 1 : 0);
            cc = c + (n == 2 ? -1 : n == 3 ? 1 : 0);
            if (rr >= 0 && rr < NR && cc >= 0 && cc < NC) pull(i, rr * NC + cc, dt);
          end
          vel[i][1] = clamp_word(longint'(vel[i][1]) + shift_tz(grav * longint'(dt), 16));
          for (int k = 0; k < 3; k++)
            vel[i][k] = clamp_word(longint'(vel[i][k]) +
                                   shift_tz(wv[k] * wf * longint'(dt), 32));
        end
        for (int k = 0; k < 3; k++)
          vel[i][k] = clamp_word(shift_tz(longint'(vel[i][k]) * m, 16));
      end
    end
    for (int n = 0; n < NP; n++)
      for (int k = 0; k < 3; k++)
        pos[n][k] = clamp_word(longint'(pos[n][k]) +
                               shift_tz(longint'(vel[n][k]) * longint'(dt), 16));
  endfunction

  // note one accepted input transfer
  function void note_input(logic cmd, logic [15:0] dt, logic [7:0] idx);
    point_report_t rep;
    if (cmd == msc_pkg::CMD_STEP) begin
      advance(u64_t'(dt));
    end else if (idx < NP) begin
      rep.point_number = idx;
      rep.pos_x = pos[idx][0];
      rep.pos_y = pos[idx][1];
      rep.pos_z = pos[idx][2];
      rep.is_anchor = pinned[idx];
      reports_due = {reports_due, rep};
    end
  endfunction

  function void check_result(point_report_t got);
    point_report_t want;
    if (reports_due.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result for point %0d", got.point_number);
      return;
    end
    want = reports_due.pop_front();
    if (got.point_number !== want.point_number || got.pos_x !== want.pos_x ||
        got.pos_y !== want.pos_y || got.pos_z !== want.pos_z ||
        got.is_anchor !== want.is_anchor) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected pt %0d (%0d,%0d,%0d) anc %0b, got pt %0d (%0d,%0d,%0d) anc %0b",
                 want.point_number, want.pos_x, want.pos_y, want.pos_z, want.is_anchor,
                 got.point_number, got.pos_x, got.pos_y, got.pos_z, got.is_anchor);
    end
  endfunction
endclass

module testbench;
  import msc_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 200000;   // far above the slowest step
  localparam int HOLD_CYCLES = 400;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_cmd;
  logic [15:0]        in_dt;
  logic [7:0]         in_point_index;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         out_point_number;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic               out_is_anchor;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  cloth_scoreboard sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_req;
  int  hold_left;
  int  quiet_cycles;

  mass_spring_cloth_step_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check results before noting new inputs, since a result seen at
  // this edge always belongs to an earlier read.
  always @(posedge clk) begin
    point_report_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.point_number = out_point_number;
        got.pos_x = out_pos_x;
        got.pos_y = out_pos_y;
        got.pos_z = out_pos_z;
        got.is_anchor = out_is_anchor;
        sb.check_result(got);
      end
      if (in_valid && in_ready) sb.note_input(in_cmd, in_dt, in_point_index);
      // Watchdog: count cycles with no transfer on either channel.
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offer one item and hold it until the transfer.
  task automatic send(logic cmd, logic [15:0] dt, logic [7:0] idx);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_dt <= dt;
    in_point_index <= idx;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic send_random();
    if ($urandom_range(99) < 9)
      send(CMD_STEP, 16'($urandom_range(65535)), 8'($urandom_range(255)));
    else if ($urandom_range(99) < 85)
      send(CMD_READ, 16'($urandom_range(65535)), 8'($urandom_range(NPTS - 1)));
    else
      send(CMD_READ, 16'($urandom_range(65535)), 8'($urandom_range(255)));
  endtask

  // Drop valid, wait for every report, then for the block to go idle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.reports_due.size() != 0);
    do @(posedge clk); while (!in_ready);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic write_winds(int lim);
    write_reg(REG_WIND_X, 32'($urandom_range(2 * lim) - lim));
    write_reg(REG_WIND_Y, 32'($urandom_range(2 * lim) - lim));
    write_reg(REG_WIND_Z, 32'($urandom_range(2 * lim) - lim));
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_READ;
    in_dt = '0;
    in_point_index = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_GRAVITY;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    quiet_cycles = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      if (phase == 0) begin
        // Directed: anchors, corners, out-of-range reads, dt extremes.
        send(CMD_READ, 16'h0000, 8'd0);
        send(CMD_READ, 16'hFFFF, 8'(COLS / 2));
        send(CMD_READ, 16'h0000, 8'(COLS - 1));
        send(CMD_READ, 16'h0000, 8'(NPTS - 1));
        send(CMD_READ, 16'h0000, 8'(NPTS));
        send(CMD_READ, 16'h0000, 8'd255);
        send(CMD_STEP, 16'h0000, 8'd0);
        send(CMD_READ, 16'h0000, 8'(COLS + 1));
        send(CMD_STEP, 16'hFFFF, 8'd255);
        for (int i = 0; i < 6; i++) send(CMD_READ, 16'h0000, 8'($urandom_range(NPTS - 1)));
        send(CMD_STEP, 16'h0800, 8'd0);
        send(CMD_READ, 16'h0000, 8'(NPTS - 1));
      end else begin
        drain();
        case (phase)
          1: begin
            // Moderate settings: opposing X and Y wind, random Z wind, no damping.
            write_reg(REG_GRAVITY, 32'($urandom_range(262144)));
            write_reg(REG_WIND_X, 32'(262144));
            write_reg(REG_WIND_Y, 32'(-262144));
            write_reg(REG_WIND_Z, 32'($urandom_range(524288) - 262144));
            write_reg(REG_WIND_FACTOR, 32'd65536);
            write_reg(REG_SPRING_GAIN, 32'd4194304);
            write_reg(REG_DAMPING, 32'd0);
          end
          2: begin
            // Damping above one can drive the factor to zero; unknown index ignored.
            write_reg(REG_GRAVITY, 32'h8000_0000);
            write_winds(262144);
            write_reg(REG_WIND_FACTOR, 32'd0);
            write_reg(REG_SPRING_GAIN, 32'd0);
            write_reg(REG_DAMPING, 32'h1_FFFF);
            write_reg(REG_UNUSED, 32'hFFFF_FFFF);
          end
          default: begin
            // Huge gravity saturates positions, so separations clip.
            write_reg(REG_GRAVITY, 32'h7FFF_FFFF);
            write_winds(262144);
            write_reg(REG_WIND_FACTOR, 32'($urandom_range(65536)));
            write_reg(REG_SPRING_GAIN, 32'($urandom_range(4194304)));
            write_reg(REG_DAMPING, 32'd65536);
          end
        endcase
      end
      for (int i = 0; i < 72; i++) begin
        if (phase == 0 && i == 10) hold_req = 1;
        send_random();
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

`default_nettype wire
